// ===== rtl/mvl_pkg.sv =====
// mvl_pkg: shared types and constants for the manhattan voronoi labeler
// holds request codes, item structs, chain token and box store control
// no dependencies
`timescale 1ns / 1ps

package mvl_pkg;

   localparam int COORD_W = 8;
   localparam int INDEX_W = 6;
   localparam int DIST_W  = 9;
   localparam int CSR_W   = 7;
   // wide enough for any table depth up to 256 entries
   localparam int BEST_W  = 8;
   localparam int COUNT_W = 9;

   typedef enum logic [1:0] {
      REQ_LOAD     = 2'd0,
      REQ_CLASSIFY = 2'd1,
      REQ_READ     = 2'd2,
      REQ_CLEAR    = 2'd3
   } req_kind_type;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [INDEX_W-1:0] seed_index;
      logic [COORD_W-1:0] coord_x;
      logic [COORD_W-1:0] coord_y;
   } req_item_type;

   typedef struct packed {
      logic [INDEX_W-1:0] nearest_index;
      logic [DIST_W-1:0]  nearest_distance;
      logic [COORD_W-1:0] box_min_x;
      logic [COORD_W-1:0] box_min_y;
      logic [COORD_W-1:0] box_max_x;
      logic [COORD_W-1:0] box_max_y;
      logic               box_empty;
   } rsp_item_type;

   typedef struct packed {
      logic               valid;
      logic [1:0]         op;
      logic [INDEX_W-1:0] idx;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [BEST_W-1:0]  best_idx;
      logic [DIST_W-1:0]  best_d;
   } chain_token_type;

   typedef struct packed {
      logic [COORD_W-1:0] min_x;
      logic [COORD_W-1:0] min_y;
      logic [COORD_W-1:0] max_x;
      logic [COORD_W-1:0] max_y;
   } box_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clear_all;
   } box_ctl_type;

endpackage

// ===== rtl/mvl_cell.sv =====
// mvl_cell: one seed cell of the search chain
// holds one seed position and updates the passing token's nearest seed
// depends on mvl_pkg
`timescale 1ns / 1ps

module mvl_cell
   import mvl_pkg::*;
#(
   parameter int CELL_IDX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  chain_token_type      up_tok,
   input  logic [COUNT_W-1:0]   seed_limit,
   output chain_token_type      down_tok
);

   logic [COORD_W-1:0] seed_x_ff;
   logic [COORD_W-1:0] seed_y_ff;
   chain_token_type    token_ff;
   chain_token_type    token_in;
   logic [COORD_W-1:0] dx;
   logic [COORD_W-1:0] dy;
   logic [DIST_W-1:0]  seed_dist;
   logic               is_mine;
   logic               in_scope;
   logic               take;

   always_comb begin
      dx       = (up_tok.x > seed_x_ff) ? (up_tok.x - seed_x_ff) : (seed_x_ff - up_tok.x);
      dy       = (up_tok.y > seed_y_ff) ? (up_tok.y - seed_y_ff) : (seed_y_ff - up_tok.y);
      seed_dist = {1'b0, dx} + {1'b0, dy};
      is_mine  = ({3'b000, up_tok.idx} == COUNT_W'(CELL_IDX));
      in_scope = (COUNT_W'(CELL_IDX) < seed_limit);
      take     = (up_tok.op == REQ_CLASSIFY) && in_scope
                 && ((CELL_IDX == 0) || (seed_dist < up_tok.best_d));
      token_in = up_tok;
      if (take) begin
         token_in.best_idx = BEST_W'(CELL_IDX);
         token_in.best_d   = seed_dist;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff.valid <= 1'b0;
      end else begin
         token_ff.valid <= token_in.valid;
      end
      token_ff.op       <= token_in.op;
      token_ff.idx      <= token_in.idx;
      token_ff.x        <= token_in.x;
      token_ff.y        <= token_in.y;
      token_ff.best_idx <= token_in.best_idx;
      token_ff.best_d   <= token_in.best_d;
      if (up_tok.valid && (up_tok.op == REQ_LOAD) && is_mine) begin
         seed_x_ff <= up_tok.x;
         seed_y_ff <= up_tok.y;
      end
   end

   assign down_tok = token_ff;

endmodule

// ===== rtl/mvl_box_store.sv =====
// mvl_box_store: region bounding box memory with per-region touched bits
// registered read port, one write port, single-cycle clear of all regions
// depends on mvl_pkg
`timescale 1ns / 1ps

module mvl_box_store
   import mvl_pkg::*;
#(
   parameter int MAX_SEEDS = 64,
   localparam int AW = $clog2(MAX_SEEDS)
) (
   input  logic           clock,
   input  logic           reset,
   input  box_ctl_type    ctl,
   input  logic [AW-1:0]  rd_addr,
   input  logic [AW-1:0]  wr_addr,
   input  box_type        wr_box,
   output box_type        rd_box,
   output logic           rd_touched
);

   box_type                mem [MAX_SEEDS];
   logic [MAX_SEEDS-1:0]   touched_ff;
   box_type                rd_box_ff;
   logic                   rd_touched_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         touched_ff <= '0;
      end else if (ctl.clear_all) begin
         touched_ff <= '0;
      end else if (ctl.wr_en) begin
         touched_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_box;
      end
      if (ctl.rd_en) begin
         rd_box_ff     <= mem[rd_addr];
         rd_touched_ff <= touched_ff[rd_addr];
      end
   end

   assign rd_box     = rd_box_ff;
   assign rd_touched = rd_touched_ff;

endmodule

// ===== rtl/manhattan_voronoi_labeler.sv =====
// manhattan_voronoi_labeler: nearest seed labeling under manhattan distance
// an item walks the seed cell chain one cell per cycle, then reads and updates the box store
// an accepted item passes the MAX_SEEDS cell registers, the box store read register, then the result register
// only one item is in flight at a time; a new request is taken once the last result is registered
// reset: synchronous, clears control, all region boxes empty, seed_count back to 64
// seed positions are undefined until loaded
`timescale 1ns / 1ps

module manhattan_voronoi_labeler
   import mvl_pkg::*;
#(
   parameter int MAX_SEEDS = 64,
   parameter int MAP_DIM   = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  req_item_type       req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output rsp_item_type       rsp_data,
   input  logic               csr_write_enable,
   input  logic [CSR_W-1:0]   csr_write_data
);

   localparam int AW    = $clog2(MAX_SEEDS);
   localparam int WIDE_W = 13;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WB
   } state_type;

   state_type          state_ff;
   logic [CSR_W-1:0]   seed_count_ff;
   logic [COUNT_W-1:0] seed_limit;
   chain_token_type    chain_tok [MAX_SEEDS+1];
   chain_token_type    tok_ff;
   rsp_item_type       rsp_data_ff;
   rsp_item_type       rsp_in;
   logic               rsp_valid_ff;
   logic               accept;
   logic               out_free;
   logic [COORD_W-1:0] clamp_x;
   logic [COORD_W-1:0] clamp_y;
   box_ctl_type        box_ctl;
   logic [AW-1:0]      rd_addr;
   logic [AW-1:0]      wr_addr;
   box_type            wr_box;
   box_type            rd_box;
   logic               rd_touched;
   logic               in_range;
   logic [COUNT_W-1:0] idx_wide;
   logic [COUNT_W-1:0] out_idx_wide;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_count_ff <= CSR_W'(64);
      end else if (csr_write_enable) begin
         seed_count_ff <= csr_write_data;
      end
   end

   always_comb begin
      if (seed_count_ff == '0) begin
         seed_limit = COUNT_W'(1);
      end else if ({2'b00, seed_count_ff} > COUNT_W'(MAX_SEEDS)) begin
         seed_limit = COUNT_W'(MAX_SEEDS);
      end else begin
         seed_limit = {2'b00, seed_count_ff};
      end
   end

   always_comb begin
      clamp_x = req_data.coord_x;
      clamp_y = req_data.coord_y;
      if ({5'b00000, clamp_x} >= WIDE_W'(MAP_DIM)) begin
         clamp_x = COORD_W'(MAP_DIM - 1);
      end
      if ({5'b00000, clamp_y} >= WIDE_W'(MAP_DIM)) begin
         clamp_y = COORD_W'(MAP_DIM - 1);
      end
   end

   always_comb begin
      chain_tok[0].valid    = accept;
      chain_tok[0].op       = req_data.req_type;
      chain_tok[0].idx      = req_data.seed_index;
      chain_tok[0].x        = clamp_x;
      chain_tok[0].y        = clamp_y;
      chain_tok[0].best_idx = '0;
      chain_tok[0].best_d   = '1;
   end

   for (genvar g = 0; g < MAX_SEEDS; g++) begin : g_cell
      mvl_cell #(
         .CELL_IDX (g)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_tok     (chain_tok[g]),
         .seed_limit (seed_limit),
         .down_tok   (chain_tok[g+1])
      );
   end

   // read address comes from the token leaving the chain
   always_comb begin
      idx_wide = {3'b000, chain_tok[MAX_SEEDS].idx};
      if (chain_tok[MAX_SEEDS].op == REQ_CLASSIFY) begin
         rd_addr = chain_tok[MAX_SEEDS].best_idx[AW-1:0];
      end else begin
         rd_addr = idx_wide[AW-1:0];
      end
   end

   assign wr_addr      = tok_ff.best_idx[AW-1:0];
   assign out_idx_wide = {3'b000, tok_ff.idx};
   assign in_range     = (out_idx_wide < COUNT_W'(MAX_SEEDS));

   always_comb begin
      rsp_in            = '0;
      wr_box            = rd_box;
      box_ctl.rd_en     = (state_ff == ST_RUN) && chain_tok[MAX_SEEDS].valid;
      box_ctl.wr_en     = 1'b0;
      box_ctl.clear_all = 1'b0;
      unique case (tok_ff.op)
         REQ_LOAD: begin
            rsp_in.box_empty = 1'b0;
         end
         REQ_CLASSIFY: begin
            if (!rd_touched) begin
               wr_box.min_x = tok_ff.x;
               wr_box.max_x = tok_ff.x;
               wr_box.min_y = tok_ff.y;
               wr_box.max_y = tok_ff.y;
            end else begin
               if (tok_ff.x < rd_box.min_x) wr_box.min_x = tok_ff.x;
               if (tok_ff.y < rd_box.min_y) wr_box.min_y = tok_ff.y;
               if (tok_ff.x > rd_box.max_x) wr_box.max_x = tok_ff.x;
               if (tok_ff.y > rd_box.max_y) wr_box.max_y = tok_ff.y;
            end
            box_ctl.wr_en           = (state_ff == ST_WB) && out_free;
            rsp_in.nearest_index    = tok_ff.best_idx[INDEX_W-1:0];
            rsp_in.nearest_distance = tok_ff.best_d;
            rsp_in.box_min_x        = wr_box.min_x;
            rsp_in.box_min_y        = wr_box.min_y;
            rsp_in.box_max_x        = wr_box.max_x;
            rsp_in.box_max_y        = wr_box.max_y;
            rsp_in.box_empty        = 1'b0;
         end
         REQ_READ: begin
            if (in_range && rd_touched) begin
               rsp_in.box_min_x = rd_box.min_x;
               rsp_in.box_min_y = rd_box.min_y;
               rsp_in.box_max_x = rd_box.max_x;
               rsp_in.box_max_y = rd_box.max_y;
               rsp_in.box_empty = 1'b0;
            end else begin
               rsp_in.box_empty = 1'b1;
            end
         end
         REQ_CLEAR: begin
            box_ctl.clear_all = (state_ff == ST_WB) && out_free;
            rsp_in.box_empty  = 1'b1;
         end
         default: begin
            rsp_in.box_empty = 1'b0;
         end
      endcase
   end

   mvl_box_store #(
      .MAX_SEEDS (MAX_SEEDS)
   ) u_box_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (box_ctl),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .wr_box     (wr_box),
      .rd_box     (rd_box),
      .rd_touched (rd_touched)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready && !((state_ff == ST_WB) && out_free)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               if (chain_tok[MAX_SEEDS].valid) begin
                  tok_ff   <= chain_tok[MAX_SEEDS];
                  state_ff <= ST_WB;
               end
            end
            ST_WB: begin
               if (out_free) begin
                  rsp_data_ff  <= rsp_in;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_chain_exit_in_run: assert property (@(posedge clock) disable iff (reset)
      chain_tok[MAX_SEEDS].valid |-> (state_ff == ST_RUN))
      else $error("item left the cell chain outside the run state");

   a_accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN))
      else $error("accepted item did not enter the cell chain");

   a_rsp_from_wb: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff ##1 rsp_valid_ff) |-> ($past(state_ff) == ST_WB))
      else $error("result raised outside the write-back state");

   a_box_write_single: assert property (@(posedge clock) disable iff (reset)
      !(box_ctl.wr_en && box_ctl.clear_all))
      else $error("box write and clear in the same cycle");
`endif

endmodule

// ===== tb/manhattan_voronoi_labeler_test.sv =====
// manhattan_voronoi_labeler_test: self-checking bench for the nearest seed labeler
// a queue-fed driver and a checking monitor; an in-bench predictor tracks seeds and boxes
// depends on mvl_pkg and manhattan_voronoi_labeler
`timescale 1ns / 1ps

module manhattan_voronoi_labeler_test;
   import mvl_pkg::*;

   localparam int SEED_SLOTS  = 64;
   localparam int MAP_SIZE    = 256;
   localparam int CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   req_item_type       req_data = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   rsp_item_type       rsp_data;
   logic               csr_write_enable = 1'b0;
   logic [CSR_W-1:0]   csr_write_data = '0;

   // predictor state
   bit [COORD_W-1:0] seed_x [SEED_SLOTS];
   bit [COORD_W-1:0] seed_y [SEED_SLOTS];
   bit [COORD_W-1:0] lo_x [SEED_SLOTS];
   bit [COORD_W-1:0] lo_y [SEED_SLOTS];
   bit [COORD_W-1:0] hi_x [SEED_SLOTS];
   bit [COORD_W-1:0] hi_y [SEED_SLOTS];
   bit               touched [SEED_SLOTS];
   bit [CSR_W-1:0]   seed_limit = 7'd64;

   // seed table as the stimulus will have left it
   bit               gen_loaded [SEED_SLOTS];
   bit [COORD_W-1:0] gen_x [SEED_SLOTS];
   bit [COORD_W-1:0] gen_y [SEED_SLOTS];

   req_item_type req_backlog [$];
   rsp_item_type awaited_rsp [$];
   rsp_item_type want;
   int           queued_total = 0;
   int           results_seen = 0;
   int           errors = 0;
   int           cycle_count = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   int           stall_left = 0;

   manhattan_voronoi_labeler #(
      .MAX_SEEDS (SEED_SLOTS),
      .MAP_DIM   (MAP_SIZE)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic int effective_span(int setting);
      if (setting < 1) return 1;
      if (setting > SEED_SLOTS) return SEED_SLOTS;
      return setting;
   endfunction

   function automatic void clear_regions();
      for (int i = 0; i < SEED_SLOTS; i++) begin
         lo_x[i] = 8'd255;
         lo_y[i] = 8'd255;
         hi_x[i] = 8'd0;
         hi_y[i] = 8'd0;
         touched[i] = 1'b0;
      end
   endfunction

   // nearest seed label and region box that one item produces
   function automatic rsp_item_type resolve_request(req_item_type item);
      rsp_item_type r;
      int span, win, best_d, d, dx, dy, box_sel;
      r = '0;
      box_sel = -1;
      case (item.req_type)
         REQ_LOAD: begin
            seed_x[item.seed_index] = item.coord_x;
            seed_y[item.seed_index] = item.coord_y;
         end
         REQ_CLASSIFY: begin
            span = effective_span(seed_limit);
            win = 0;
            best_d = 0;
            for (int i = 0; i < span; i++) begin
               dx = (item.coord_x > seed_x[i]) ? item.coord_x - seed_x[i]
                                               : seed_x[i] - item.coord_x;
               dy = (item.coord_y > seed_y[i]) ? item.coord_y - seed_y[i]
                                               : seed_y[i] - item.coord_y;
               d = dx + dy;
               if (i == 0 || d < best_d) begin
                  best_d = d;
                  win = i;
               end
            end
            if (!touched[win]) begin
               touched[win] = 1'b1;
               lo_x[win] = item.coord_x;
               hi_x[win] = item.coord_x;
               lo_y[win] = item.coord_y;
               hi_y[win] = item.coord_y;
            end else begin
               if (item.coord_x < lo_x[win]) lo_x[win] = item.coord_x;
               if (item.coord_y < lo_y[win]) lo_y[win] = item.coord_y;
               if (item.coord_x > hi_x[win]) hi_x[win] = item.coord_x;
               if (item.coord_y > hi_y[win]) hi_y[win] = item.coord_y;
            end
            r.nearest_index = win[INDEX_W-1:0];
            r.nearest_distance = best_d[DIST_W-1:0];
            box_sel = win;
         end
         REQ_READ: begin
            box_sel = item.seed_index;
         end
         default: begin
            clear_regions();
            r.box_empty = 1'b1;
         end
      endcase
      if (box_sel >= 0) begin
         if (touched[box_sel]) begin
            r.box_min_x = lo_x[box_sel];
            r.box_min_y = lo_y[box_sel];
            r.box_max_x = hi_x[box_sel];
            r.box_max_y = hi_y[box_sel];
         end else begin
            r.box_empty = 1'b1;
         end
      end
      return r;
   endfunction

   function automatic int any_coord();
      case ($urandom_range(0, 7))
         0: return 0;
         1: return MAP_SIZE - 1;
         default: return $urandom_range(0, MAP_SIZE - 1);
      endcase
   endfunction

   function automatic int nudge(int base);
      int v;
      v = base + $urandom_range(0, 6) - 3;
      if (v < 0) v = 0;
      if (v > MAP_SIZE - 1) v = MAP_SIZE - 1;
      return v;
   endfunction

   task automatic queue_item(req_kind_type kind, int idx, int x, int y);
      req_item_type item;
      item.req_type = kind;
      item.seed_index = idx[INDEX_W-1:0];
      item.coord_x = x[COORD_W-1:0];
      item.coord_y = y[COORD_W-1:0];
      if (kind == REQ_LOAD) begin
         gen_loaded[item.seed_index] = 1'b1;
         gen_x[item.seed_index] = item.coord_x;
         gen_y[item.seed_index] = item.coord_y;
      end
      queued_total++;
      req_backlog.push_back(item);
   endtask

   task automatic write_seed_count(int value);
      wait (results_seen == queued_total);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value[CSR_W-1:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      seed_limit = value[CSR_W-1:0];
   endtask

   // mostly pixels, with loads, box reads and the odd clear; a pixel is only
   // sent once every searched seed has been loaded
   task automatic random_items(int n_items, int span);
      int pick, first_gap, j, x, y;
      for (int k = 0; k < n_items; k++) begin
         pick = $urandom_range(0, 99);
         first_gap = -1;
         for (int i = span - 1; i >= 0; i--)
            if (!gen_loaded[i]) first_gap = i;
         if (pick < 55) begin
            if (first_gap >= 0) begin
               queue_item(REQ_LOAD, first_gap, any_coord(), any_coord());
            end else if ($urandom_range(0, 3) == 0) begin
               j = $urandom_range(0, span - 1);
               queue_item(REQ_CLASSIFY, $urandom_range(0, 63), nudge(gen_x[j]),
                          nudge(gen_y[j]));
            end else begin
               queue_item(REQ_CLASSIFY, $urandom_range(0, 63), any_coord(), any_coord());
            end
         end else if (pick < 72) begin
            j = $urandom_range(0, SEED_SLOTS - 1);
            x = any_coord();
            y = any_coord();
            // duplicate positions force distance ties
            if ($urandom_range(0, 3) == 0 && gen_loaded[j]) begin
               x = gen_x[j];
               y = gen_y[j];
            end
            queue_item(REQ_LOAD, $urandom_range(0, SEED_SLOTS - 1), x, y);
         end else if (pick < 97) begin
            j = ($urandom_range(0, 1) == 0) ? $urandom_range(0, span - 1)
                                            : $urandom_range(0, SEED_SLOTS - 1);
            queue_item(REQ_READ, j, any_coord(), any_coord());
         end else begin
            queue_item(REQ_CLEAR, $urandom_range(0, 63), any_coord(), any_coord());
         end
      end
   endtask

   task automatic check_field(string name, logic [15:0] expv, logic [15:0] actv);
      if (expv !== actv) begin
         $display("%0t %s mismatch: expected %0d actual %0d", $time, name, expv, actv);
         errors++;
      end
   endtask

   // driver: bursts of items with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            awaited_rsp.push_back(resolve_request(req_data));
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_data <= req_backlog.pop_front();
               req_valid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each result and stalls in its own pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               $display("%0t unexpected item: expected none, actual %p", $time, rsp_data);
               errors++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("nearest_index", want.nearest_index, rsp_data.nearest_index);
               check_field("nearest_distance", want.nearest_distance,
                           rsp_data.nearest_distance);
               check_field("box_min_x", want.box_min_x, rsp_data.box_min_x);
               check_field("box_min_y", want.box_min_y, rsp_data.box_min_y);
               check_field("box_max_x", want.box_max_x, rsp_data.box_max_x);
               check_field("box_max_y", want.box_max_y, rsp_data.box_max_y);
               check_field("box_empty", want.box_empty, rsp_data.box_empty);
               results_seen++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            // every third stretch runs without stalls
            if ((cycle_count / 3000) % 3 != 2 && $urandom_range(0, 5) == 0)
               stall_left = $urandom_range(1, 20);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("manhattan_voronoi_labeler_test: done, errors");
         $finish;
      end
   end

   initial begin
      int phase_setting [8];
      int setting;
      phase_setting = '{64, 127, 1, 2, 100, 0, 0, 64};
      clear_regions();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset setting: empty boxes, clear, extreme seed positions
      queue_item(REQ_READ, 0, 0, 0);
      queue_item(REQ_READ, 63, 255, 255);
      queue_item(REQ_CLEAR, 0, 0, 0);
      queue_item(REQ_READ, 5, 0, 0);
      queue_item(REQ_LOAD, 0, 0, 0);
      queue_item(REQ_LOAD, 1, 255, 255);
      queue_item(REQ_LOAD, 2, 0, 255);
      queue_item(REQ_LOAD, 3, 128, 128);
      queue_item(REQ_LOAD, 63, 255, 0);
      random_items(70, effective_span(seed_limit));

      // zero count searches one seed; farthest pixel gives the largest distance
      write_seed_count(0);
      queue_item(REQ_LOAD, 0, 0, 0);
      queue_item(REQ_LOAD, 1, 255, 255);
      queue_item(REQ_LOAD, 2, 0, 255);
      queue_item(REQ_LOAD, 3, 128, 128);
      queue_item(REQ_CLEAR, 0, 0, 0);
      queue_item(REQ_CLASSIFY, 0, 0, 0);
      queue_item(REQ_CLASSIFY, 0, 255, 255);
      queue_item(REQ_READ, 0, 0, 0);

      // ties go to the lowest index; clear then rebuild a box
      write_seed_count(4);
      queue_item(REQ_CLASSIFY, 0, 128, 0);
      queue_item(REQ_CLASSIFY, 0, 255, 0);
      queue_item(REQ_CLASSIFY, 0, 255, 255);
      queue_item(REQ_CLASSIFY, 0, 0, 254);
      queue_item(REQ_READ, 1, 0, 0);
      queue_item(REQ_READ, 2, 0, 0);
      queue_item(REQ_CLEAR, 0, 0, 0);
      queue_item(REQ_READ, 0, 0, 0);
      queue_item(REQ_CLASSIFY, 0, 1, 1);

      for (int p = 0; p < 8; p++) begin
         setting = (p == 6) ? $urandom_range(3, 63) : phase_setting[p];
         write_seed_count(setting);
         random_items(55, effective_span(setting));
      end

      wait (results_seen == queued_total);
      repeat (SEED_SLOTS + 8) @(posedge clock);
      if (awaited_rsp.size() != 0) begin
         $display("%0t missing items: expected %0d more, actual 0", $time,
                  awaited_rsp.size());
         errors++;
      end
      if (errors == 0) begin
         $display("manhattan_voronoi_labeler_test: done, clean");
      end else begin
         $display("manhattan_voronoi_labeler_test: done, errors");
      end
      $finish;
   end

endmodule
